[rtl/opmes_pkg.sv]
// ============================================================================
// opmes_pkg
// Shared constants for the ORAM position map and eviction scheduler.
// ============================================================================
package opmes_pkg;

    // Fixed field widths
    localparam int ADDR_W = 12;
    localparam int CFG_W  = 8;
    localparam int CNT_W  = 8;

    // Default tree shape
    localparam int LEVELS_DEFAULT     = 10;
    localparam int REAL_SLOTS_DEFAULT = 4;

    // Request codes
    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Eviction interval after reset
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 8'd1;

endpackage

[rtl/opmes_ram.sv]
// ============================================================================
// opmes_ram
// Generic single-port-write, single-port-read RAM with registered,
// read-first output.
// ============================================================================
module opmes_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4092,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/opmes_evict_sched.sv]
// ============================================================================
// opmes_evict_sched
// Access counter, eviction interval register and reverse-lexicographic
// eviction pointer.
// ============================================================================
module opmes_evict_sched #(
    parameter int LEVELS = opmes_pkg::LEVELS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [opmes_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                         bump,
    output logic                         evict_due,
    output logic [LEVELS-1:0]            evict_leaf
);

    localparam int PTR_W = LEVELS - 1;

    logic [opmes_pkg::CFG_W-1:0] interval_reg;
    logic [opmes_pkg::CNT_W-1:0] counter_reg;
    logic [opmes_pkg::CNT_W-1:0] counter_next;
    logic [PTR_W-1:0]            pointer_reg;
    logic [PTR_W-1:0]            pointer_next;
    logic [opmes_pkg::CNT_W:0]   count_inc;
    logic [PTR_W-1:0]            pointer_rev;

    // Wrap when the incremented count reaches the interval
    assign count_inc = {1'b0, counter_reg} + {{opmes_pkg::CNT_W{1'b0}}, 1'b1};
    assign evict_due = bump && (count_inc >= {1'b0, interval_reg});

    always_comb
    begin
        counter_next = counter_reg;
        pointer_next = pointer_reg;
        if (bump)
        begin
            if (evict_due)
            begin
                counter_next = '0;
                pointer_next = pointer_reg + {{(PTR_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                counter_next = count_inc[opmes_pkg::CNT_W-1:0];
            end
        end
    end

    // Descend from the root LSB first: leaf = first leaf + bit-reversed pointer
    always_comb
    begin
        for (int i = 0; i < PTR_W; i++)
        begin
            pointer_rev[i] = pointer_reg[PTR_W-1-i];
        end
    end

    assign evict_leaf = {1'b0, pointer_rev} + {1'b0, {PTR_W{1'b1}}};

    // Hold interval, counter and pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= opmes_pkg::INTERVAL_RESET;
            counter_reg  <= '0;
            pointer_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
            counter_reg <= counter_next;
            pointer_reg <= pointer_next;
        end
    end

endmodule

[rtl/oram_position_map_evict_scheduler.sv]
// ============================================================================
// oram_position_map_evict_scheduler
// Tree-ORAM client position map with path-eviction scheduling.
// ============================================================================
// Takes one word per cycle unless the output stalls, and returns one result
// word for each through the first stage and the output register. The map
// read is a registered synchronous read; the fresh leaf is written in
// the same cycle as the read (the memory returns the old data), so a following
// access to the same address always sees it. The map memory has no reset and
// no clearing pass: an address must be loaded before it is accessed. Loads
// and stash hits return all-zero fields and leave the counter alone.
module oram_position_map_evict_scheduler #(
    parameter int LEVELS     = opmes_pkg::LEVELS_DEFAULT,
    parameter int REAL_SLOTS = opmes_pkg::REAL_SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [opmes_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [opmes_pkg::ADDR_W-1:0]  address,
    input  logic [LEVELS-2:0]             random_leaf,
    input  logic                          in_stash,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          read_valid,
    output logic [LEVELS-1:0]             read_leaf,
    output logic [LEVELS-1:0]             new_leaf,
    output logic                          evict_valid,
    output logic [LEVELS-1:0]             evict_leaf
);

    localparam int PTR_W     = LEVELS - 1;
    localparam int MAP_DEPTH = ((1 << LEVELS) - 1) * REAL_SLOTS;
    localparam int ADDR_SPAN = 1 << opmes_pkg::ADDR_W;
    localparam int RAM_DEPTH = (MAP_DEPTH < ADDR_SPAN) ? MAP_DEPTH : ADDR_SPAN;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    logic              accept;
    logic              advance;
    logic              in_range;
    logic              is_access;
    logic              map_we;
    logic [LEVELS-1:0] fresh;
    logic [LEVELS-1:0] map_rd_data;
    logic              sched_due;
    logic [LEVELS-1:0] sched_leaf;

    // First stage: map read in flight
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_access_reg;
    logic              s1_in_range_reg;
    logic [LEVELS-1:0] s1_new_leaf_reg;
    logic              s1_evict_reg;
    logic [LEVELS-1:0] s1_evict_leaf_reg;

    // Output stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              read_valid_reg;
    logic [LEVELS-1:0] read_leaf_reg;
    logic [LEVELS-1:0] new_leaf_reg;
    logic              evict_valid_reg;
    logic [LEVELS-1:0] evict_leaf_reg;

    // Handshake: first stage moves on when the output register is free
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // Decode the incoming word
    assign in_range  = 32'(address) < 32'(MAP_DEPTH);
    assign is_access = (req_type == opmes_pkg::REQ_ACCESS) && !in_stash;
    assign fresh     = {1'b0, random_leaf} + {1'b0, {PTR_W{1'b1}}};
    assign map_we    = accept && in_range
                       && ((req_type == opmes_pkg::REQ_LOAD) || is_access);

    opmes_ram #(
        .WIDTH (LEVELS),
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_map (
        .clk     (clk),
        .we      (map_we),
        .wr_addr (address[RAM_AW-1:0]),
        .wr_data (fresh),
        .re      (accept),
        .rd_addr (address[RAM_AW-1:0]),
        .rd_data (map_rd_data)
    );

    opmes_evict_sched #(
        .LEVELS (LEVELS)
    ) u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .bump        (accept && is_access),
        .evict_due   (sched_due),
        .evict_leaf  (sched_leaf)
    );

    // Advance valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the first-stage payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_access_reg     <= is_access;
            s1_in_range_reg   <= in_range;
            s1_new_leaf_reg   <= is_access ? fresh : '0;
            s1_evict_reg      <= sched_due;
            s1_evict_leaf_reg <= sched_due ? sched_leaf : '0;
        end
    end

    // Load the output word; the old leaf comes from the map read
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            read_valid_reg  <= s1_access_reg;
            read_leaf_reg   <= (s1_access_reg && s1_in_range_reg) ? map_rd_data : '0;
            new_leaf_reg    <= s1_new_leaf_reg;
            evict_valid_reg <= s1_evict_reg;
            evict_leaf_reg  <= s1_evict_leaf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_valid  = read_valid_reg;
    assign read_leaf   = read_leaf_reg;
    assign new_leaf    = new_leaf_reg;
    assign evict_valid = evict_valid_reg;
    assign evict_leaf  = evict_leaf_reg;

endmodule
